### rtl/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg: shared types and constants of the trouble code status table
// Status bit positions, operating modes, item and result layouts, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dtc_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int RESULT_LIMIT  = 16;
	localparam int LIMIT_W       = 5;
	localparam int CFG_IDX_W     = 4;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_AVAIL_MASK  = CFG_IDX_W'(1);

	localparam logic [4:0] ENTRY_COUNT_RST = 5'd16;
	localparam logic [7:0] AVAIL_MASK_RST  = 8'hFF;

	localparam int ST_TF     = 0;
	localparam int ST_TFTOC  = 1;
	localparam int ST_PDTC   = 2;
	localparam int ST_CDTC   = 3;
	localparam int ST_TNCSLC = 4;
	localparam int ST_TFSLC  = 5;
	localparam int ST_TNCTOC = 6;

	localparam logic [7:0] ST_INITIAL = 8'h50;
	localparam logic [7:0] CTR_MAX    = 8'hFF;

	typedef enum logic [2:0] {
		MODE_LOAD   = 3'd0,
		MODE_REPORT = 3'd1,
		MODE_CYCLE  = 3'd2,
		MODE_CLEAR  = 3'd3,
		MODE_GET    = 3'd4,
		MODE_COUNT  = 3'd5,
		MODE_LIST   = 3'd6
	} mode_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  entry_index;
		logic        test_failed;
		logic [7:0]  status_mask;
		logic [7:0]  max_records;
		logic [23:0] load_code;
		logic [7:0]  load_threshold;
	} item_t;

	typedef struct packed {
		logic [7:0]  status_out;
		logic [4:0]  match_count;
		logic [23:0] code_out;
		logic        record_valid;
		logic        last_record;
	} result_t;

	typedef struct packed {
		logic accept;
		logic load_wr;
		logic clear_all;
		logic rd_idx;
		logic walk_start;
		logic walk_en;
		logic report_wr;
		logic push_get;
		logic push_count;
		logic push_tail;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       in_range;
		logic       walk_done;
		logic       slot_free;
	} sts_t;

endpackage

### rtl/dtc_ifs.sv
// ----------------------------------------------------------------------------
// dtc_ifs: channel interfaces of the trouble code status table
// Request item channel, result channel and register write channel, each with
// a valid and ready handshake.
// ----------------------------------------------------------------------------
interface dtc_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [7:0]  entry_index;
	logic        test_failed;
	logic [7:0]  status_mask;
	logic [7:0]  max_records;
	logic [23:0] load_code;
	logic [7:0]  load_threshold;

	modport source (output valid, output mode, output entry_index, output test_failed,
		output status_mask, output max_records, output load_code, output load_threshold,
		input ready);
	modport sink (input valid, input mode, input entry_index, input test_failed,
		input status_mask, input max_records, input load_code, input load_threshold,
		output ready);
endinterface

interface dtc_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  status_out;
	logic [4:0]  match_count;
	logic [23:0] code_out;
	logic        record_valid;
	logic        last_record;

	modport source (output valid, output status_out, output match_count, output code_out,
		output record_valid, output last_record, input ready);
	modport sink (input valid, input status_out, input match_count, input code_out,
		input record_valid, input last_record, output ready);
endinterface

interface dtc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [dtc_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/dtc_ctrl.sv
// ----------------------------------------------------------------------------
// dtc_ctrl: sequencing state machine of the trouble code status table
// Accepts one request, decodes its mode and steps the datapath through a
// single-entry access or a walk over the active entries.
// ----------------------------------------------------------------------------
module dtc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dtc_pkg::sts_t  sts,
	output dtc_pkg::cmd_t  cmd
);
	import dtc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_SINGLE = 5'b00100,
		S_WALK   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				unique case (mode_t'(sts.mode))
					MODE_LOAD: begin
						cmd.load_wr = sts.in_range;
					end
					MODE_CLEAR: begin
						cmd.clear_all = 1'b1;
					end
					MODE_REPORT, MODE_GET: begin
						cmd.rd_idx = 1'b1;
						state_d    = S_SINGLE;
					end
					MODE_CYCLE, MODE_COUNT, MODE_LIST: begin
						cmd.walk_start = 1'b1;
						state_d        = S_WALK;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_SINGLE: begin
				if (sts.mode == MODE_REPORT) begin
					cmd.report_wr = sts.in_range;
					state_d       = S_IDLE;
				end else if (sts.slot_free) begin
					cmd.push_get = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_WALK: begin
				cmd.walk_en = sts.slot_free;
				if (sts.walk_done) begin
					state_d = (sts.mode == MODE_CYCLE) ? S_IDLE : S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.slot_free) begin
					if (sts.mode == MODE_COUNT) begin
						cmd.push_count = 1'b1;
					end else begin
						cmd.push_tail = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/dtc_datapath.sv
// ----------------------------------------------------------------------------
// dtc_datapath: entry storage and status arithmetic of the status table
// Holds the configuration registers, the request registers, the entry
// memories with their valid bits, the walk pointer and the result register.
// ----------------------------------------------------------------------------
module dtc_datapath #(
	parameter int MAX_ENTRIES = dtc_pkg::TABLE_ENTRIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dtc_pkg::item_t                 item_d,
	input  logic                           cfg_we,
	input  logic [dtc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	input  dtc_pkg::cmd_t                  cmd,
	output dtc_pkg::sts_t                  sts,
	input  logic                           res_ready,
	output logic                           res_valid,
	output dtc_pkg::result_t               res_d
);
	import dtc_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [7:0] MAX_N = 8'(MAX_ENTRIES);
	localparam logic [7:0] LIMIT_MAX = 8'(RESULT_LIMIT);

	logic [4:0] entry_count_q;
	logic [7:0] avail_q;

	logic [2:0]         mode_q;
	logic [AW-1:0]      idx_q;
	logic               failed_q;
	logic [7:0]         smask_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [23:0]        lcode_q;
	logic [7:0]         lthr_q;
	logic [CW-1:0]      n_q;
	logic               range_q;

	logic [7:0] ec_ext, n_full, lim_full;

	logic [15:0]          ent_mem [MAX_ENTRIES];
	logic [31:0]          cm_mem  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] vld_q;
	logic [15:0]          ent_rd_q;
	logic [31:0]          cm_rd_q;
	logic                 vrd_q;

	logic [CW-1:0]      ptr_q;
	logic               v_s1;
	logic [AW-1:0]      e_s1;
	logic               stop_q;
	logic [LIMIT_W-1:0] k_q;
	logic [CW-1:0]      cnt_q;
	logic               pend_v_q;
	logic [7:0]         pend_st_q;
	logic [23:0]        pend_code_q;

	logic               out_valid_q;
	result_t            res_q, res_n;

	logic          issue, rd_en, proc, match, list_hit, push;
	logic [AW-1:0] raddr;
	logic          ent_we;
	logic [AW-1:0] ent_waddr;
	logic [15:0]   ent_wdata;
	logic [7:0]    st_cur, ctr_cur, thr_eff, ctr_rep, st_rep, st_cyc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= ENTRY_COUNT_RST;
			avail_q       <= AVAIL_MASK_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_ENTRY_COUNT) begin
				entry_count_q <= cfg_data[4:0];
			end else if (cfg_index == REG_AVAIL_MASK) begin
				avail_q <= cfg_data;
			end
		end
	end

	assign ec_ext   = {3'b000, entry_count_q};
	assign n_full   = (ec_ext > MAX_N) ? MAX_N : ec_ext;
	assign lim_full = (item_d.max_records > LIMIT_MAX) ? LIMIT_MAX : item_d.max_records;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q   <= item_d.mode;
			idx_q    <= item_d.entry_index[AW-1:0];
			failed_q <= item_d.test_failed;
			smask_q  <= item_d.status_mask;
			limit_q  <= lim_full[LIMIT_W-1:0];
			lcode_q  <= item_d.load_code;
			lthr_q   <= item_d.load_threshold;
			n_q      <= n_full[CW-1:0];
			range_q  <= (item_d.entry_index < n_full);
		end
	end

	// An entry whose valid bit is clear reads as freshly cleared.
	assign st_cur  = vrd_q ? ent_rd_q[7:0] : ST_INITIAL;
	assign ctr_cur = vrd_q ? ent_rd_q[15:8] : 8'h00;
	assign thr_eff = (cm_rd_q[7:0] == 8'h00) ? 8'h01 : cm_rd_q[7:0];
	assign match   = |(st_cur & smask_q & avail_q);

	always_comb begin
		ctr_rep = 8'h00;
		st_rep  = st_cur;
		st_rep[ST_TNCTOC] = 1'b0;
		st_rep[ST_TNCSLC] = 1'b0;
		if (failed_q) begin
			ctr_rep = (ctr_cur == CTR_MAX) ? ctr_cur : ctr_cur + 8'h01;
			st_rep[ST_TF]    = 1'b1;
			st_rep[ST_TFTOC] = 1'b1;
			st_rep[ST_TFSLC] = 1'b1;
			st_rep[ST_PDTC]  = 1'b1;
			if (ctr_rep >= thr_eff) begin
				st_rep[ST_CDTC] = 1'b1;
			end
		end else begin
			st_rep[ST_TF] = 1'b0;
		end
	end

	always_comb begin
		st_cyc = st_cur;
		if (!st_cur[ST_TFTOC]) begin
			st_cyc[ST_PDTC] = 1'b0;
		end
		st_cyc[ST_TFTOC]  = 1'b0;
		st_cyc[ST_TNCTOC] = 1'b1;
	end

	assign issue    = cmd.walk_en && (ptr_q < n_q) && !stop_q;
	assign rd_en    = cmd.rd_idx || issue;
	assign raddr    = cmd.rd_idx ? idx_q : ptr_q[AW-1:0];
	assign proc     = cmd.walk_en && v_s1 && !stop_q;
	assign list_hit = proc && (mode_q == MODE_LIST) && match;

	assign ent_we    = cmd.report_wr || (proc && (mode_q == MODE_CYCLE));
	assign ent_waddr = cmd.report_wr ? idx_q : e_s1;
	assign ent_wdata = cmd.report_wr ? {ctr_rep, st_rep} : {ctr_cur, st_cyc};

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			cm_mem[idx_q] <= {lcode_q, lthr_q};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ent_rd_q <= ent_mem[raddr];
			cm_rd_q  <= cm_mem[raddr];
			vrd_q    <= vld_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.clear_all) begin
			vld_q <= '0;
		end else if (ent_we) begin
			vld_q[ent_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			v_s1     <= 1'b0;
			stop_q   <= 1'b0;
			k_q      <= '0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
		end else if (cmd.walk_start) begin
			ptr_q    <= '0;
			v_s1     <= 1'b0;
			stop_q   <= (mode_q == MODE_LIST) && (limit_q == '0);
			k_q      <= '0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
		end else if (cmd.walk_en) begin
			v_s1 <= issue;
			if (issue) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (proc && (mode_q == MODE_COUNT) && match) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (list_hit) begin
				k_q      <= k_q + LIMIT_W'(1);
				pend_v_q <= 1'b1;
				if (k_q + LIMIT_W'(1) == limit_q) begin
					stop_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			e_s1 <= ptr_q[AW-1:0];
		end
		if (list_hit) begin
			pend_st_q   <= st_cur & avail_q;
			pend_code_q <= cm_rd_q[31:8];
		end
	end

	// A list record is held back until the next match or the end of the walk
	// shows whether it is the final one.
	assign push = cmd.push_get || cmd.push_count || cmd.push_tail || (list_hit && pend_v_q);

	always_comb begin
		res_n = '0;
		priority if (cmd.push_get) begin
			res_n.status_out  = range_q ? st_cur : 8'h00;
			res_n.last_record = 1'b1;
		end else if (cmd.push_count) begin
			res_n.match_count = 5'(cnt_q);
			res_n.last_record = 1'b1;
		end else if (cmd.push_tail) begin
			res_n.last_record = 1'b1;
			if (pend_v_q) begin
				res_n.status_out   = pend_st_q;
				res_n.code_out     = pend_code_q;
				res_n.record_valid = 1'b1;
			end
		end else begin
			res_n.status_out   = pend_st_q;
			res_n.code_out     = pend_code_q;
			res_n.record_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res_n;
		end
	end

	assign res_valid     = out_valid_q;
	assign res_d         = res_q;
	assign sts.mode      = mode_q;
	assign sts.in_range  = range_q;
	assign sts.walk_done = !v_s1 && ((ptr_q >= n_q) || stop_q);
	assign sts.slot_free = !out_valid_q || res_ready;

endmodule

### rtl/dtc_status_table.sv
// ----------------------------------------------------------------------------
// dtc_status_table: diagnostic trouble code status table
// Keeps a status byte and a consecutive-failure counter per trouble code
// entry and answers status, count and list queries.
//
//   Channel   Direction   Payload                                   Transaction
//   item      in          mode, index, result, mask, limit, load    valid & ready
//   result    out         status, count, code, record flag, last    valid & ready
//   cfg       in          register index, write data                valid & ready
//
// Load and clear finish in the decode state; report and get status pass on
// through the single-access state. Cycle start, count and list walk over the
// active entries; the walk reads one entry per cycle from the single read
// port of the entry memory. A stalled result channel freezes the walk. Reset
// leaves every entry in its cleared state at once, through per-entry valid
// bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dtc_status_table #(
	parameter int MAX_ENTRIES = dtc_pkg::TABLE_ENTRIES
) (
	input  logic         clk,
	input  logic         arst_n,
	dtc_item_if.sink     item,
	dtc_result_if.source result,
	dtc_cfg_if.sink      cfg
);
	import dtc_pkg::*;

	item_t   item_d;
	result_t res_d;
	cmd_t    cmd;
	sts_t    sts;
	logic    in_ready;
	logic    res_valid;

	assign item_d.mode           = item.mode;
	assign item_d.entry_index    = item.entry_index;
	assign item_d.test_failed    = item.test_failed;
	assign item_d.status_mask    = item.status_mask;
	assign item_d.max_records    = item.max_records;
	assign item_d.load_code      = item.load_code;
	assign item_d.load_threshold = item.load_threshold;
	assign item.ready            = in_ready;

	assign cfg.ready = 1'b1;

	dtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dtc_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_d    (item_d),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.sts       (sts),
		.res_ready (result.ready),
		.res_valid (res_valid),
		.res_d     (res_d)
	);

	assign result.valid        = res_valid;
	assign result.status_out   = res_d.status_out;
	assign result.match_count  = res_d.match_count;
	assign result.code_out     = res_d.code_out;
	assign result.record_valid = res_d.record_valid;
	assign result.last_record  = res_d.last_record;

endmodule
